>>> rtl/core/pisc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI speed controller package
// Field widths, microcode encodings and the control program of the
// sequencer that runs one sampling tick through the shared multiplier.
// ----------------------------------------------------------------------------
package pisc_pkg;

    // Field widths of the stream words.
    localparam int DELTA_W  = 16;
    localparam int TARGET_W = 8;
    localparam int DUTY_W   = 7;
    localparam int CMP_W    = 16;
    localparam int ERR_W    = 17;
    localparam int INTEG_W  = 12;
    localparam int COUNT_W  = 32;
    localparam int GEAR_W   = 14;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 136;

    // Configuration port.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam int GAIN_W = 8;
    localparam int PER_W  = 16;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 8'd1;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 8'd1;
    localparam logic [PER_W-1:0]  PWM_PERIOD_RST = 16'd1200;

    // Defaults of the top level parameters.
    localparam int GEAR_MODULUS_DEF   = 12800;
    localparam int INTEGRAL_LIMIT_DEF = 3200;

    // Controller constants.
    localparam int DUTY_MAX   = 100;
    localparam int SUM_SHIFT  = 5;
    localparam int SUM_W      = 27;

    // Compare value: floor(x / 100) as (x * CMP_RECIP) >> CMP_SHIFT, exact for
    // every product of a duty percent and a 16-bit period.
    localparam int CMP_X_W   = 23;
    localparam int CMP_SHIFT = 30;
    localparam int CMP_RC_W  = 24;
    localparam logic [CMP_RC_W-1:0] CMP_RECIP =
        CMP_RC_W'(((1 << CMP_SHIFT) + DUTY_MAX - 1) / DUTY_MAX);

    // Gear remainder: offset gear sum and its quotient estimate.
    localparam int GV_W = 17;

    // Shared multiplier.
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;

    // Microcode.
    localparam int STEP_W = 3;

    typedef enum logic [1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_PWM_PERIOD = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        MUL_NONE     = 3'd0,
        MUL_ERR_IG   = 3'd1,
        MUL_ERR_PG   = 3'd2,
        MUL_GV_RCP   = 3'd3,
        MUL_DUTY_PER = 3'd4,
        MUL_Q_MOD    = 3'd5,
        MUL_X_RCP    = 3'd6
    } t_mul_sel;

    typedef enum logic [2:0] {
        WB_NONE   = 3'd0,
        WB_LOAD   = 3'd1,
        WB_INTEG  = 3'd2,
        WB_DUTY   = 3'd3,
        WB_GQ     = 3'd4,
        WB_X      = 3'd5,
        WB_GREM   = 3'd6,
        WB_FINISH = 3'd7
    } t_wb_op;

    typedef enum logic [1:0] {
        CND_ALWAYS  = 2'd0,
        CND_IN_WORD = 2'd1,
        CND_OUT_FREE = 2'd2
    } t_cond;

    typedef struct packed {
        t_mul_sel          mul;
        t_wb_op            wb;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uc_word;

    // Control program. The write-back of a step consumes the product issued
    // by the step before it. A step whose condition fails holds in place.
    function automatic t_uc_word uc_rom(input logic [STEP_W-1:0] addr);
        t_uc_word w;
        case (addr)
            3'd0:    w = '{MUL_NONE,     WB_LOAD,   CND_IN_WORD,  3'd1};
            3'd1:    w = '{MUL_ERR_IG,   WB_NONE,   CND_ALWAYS,   3'd2};
            3'd2:    w = '{MUL_ERR_PG,   WB_INTEG,  CND_ALWAYS,   3'd3};
            3'd3:    w = '{MUL_GV_RCP,   WB_DUTY,   CND_ALWAYS,   3'd4};
            3'd4:    w = '{MUL_DUTY_PER, WB_GQ,     CND_ALWAYS,   3'd5};
            3'd5:    w = '{MUL_Q_MOD,    WB_X,      CND_ALWAYS,   3'd6};
            3'd6:    w = '{MUL_X_RCP,    WB_GREM,   CND_ALWAYS,   3'd7};
            3'd7:    w = '{MUL_NONE,     WB_FINISH, CND_OUT_FREE, 3'd0};
            default: w = '{MUL_NONE,     WB_NONE,   CND_ALWAYS,   3'd0};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/pi_speed_controller_with_position_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI speed controller with travel counters and gear position
// Microcoded PI loop with anti-windup clamp, PWM compare scaling, signed
// travel and segment counters and a gear position modulo GEAR_MODULUS.
// ----------------------------------------------------------------------------
// Usage:
// One word on the slave stream is one sampling tick. It carries the encoder
// delta, the target speed, the direction and the clear flags. For every tick
// the master stream delivers one word with the duty percent, the PWM compare
// value, the speed error, the integral and the travel, segment and gear
// counters as they stand after that tick.
// The gains and the PWM period are set through the APB-style port; they must be
// written only while no tick is in flight; the block does not enforce this.
// Sequencing: a tick is taken in step 0 of an eight-step control program and
// its result is loaded into the output register in step 7; only then does
// the program return to step 0 for the next tick. It shares the one 25 x 25
// multiplier over six products.
// Reset (synchronous, active low) restores the register defaults, clears the
// integral, both counters and the gear position and returns to step 0.
// If the receiver stalls, the result waits in the output register while the
// next tick is already taken and worked on; the program then holds in its
// last step until the output register is free.
// ----------------------------------------------------------------------------
module pi_speed_controller_with_position_core #(
    parameter int GEAR_MODULUS   = pisc_pkg::GEAR_MODULUS_DEF,
    parameter int INTEGRAL_LIMIT = pisc_pkg::INTEGRAL_LIMIT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Slave stream, one tick per word.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // From bit 0: encoder_delta[15:0], target_speed[7:0], reverse,
    // clear_travel, clear_segment, zero_position, four zero bits.
    input  logic [pisc_pkg::IN_W-1:0]     i_s_tdata,
    // Master stream, one result word per tick.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // From bit 0: duty_percent[6:0], compare_value[15:0], speed_error[16:0],
    // integral_value[11:0], travel_ticks[31:0], segment_ticks[31:0],
    // gear_angle[13:0], six zero bits.
    output logic [pisc_pkg::OUT_W-1:0]    o_m_tdata,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pisc_pkg::APB_AW-1:0]   paddr,
    input  logic [pisc_pkg::APB_DW-1:0]   pwdata,
    output logic [pisc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // Derived gear constants. The sum gear + delta is lifted by a whole
    // number of turns so that it is never negative, then reduced with a
    // reciprocal estimate that is low by at most one turn.
    localparam int HALF_DELTA = 1 << (pisc_pkg::DELTA_W - 1);
    localparam int GEAR_OFS_I =
        ((HALF_DELTA + GEAR_MODULUS - 1) / GEAR_MODULUS) * GEAR_MODULUS;
    localparam int GEAR_RCP_I = (1 << pisc_pkg::GV_W) / GEAR_MODULUS;

    localparam logic [pisc_pkg::GV_W:0]   GEAR_OFS  = (pisc_pkg::GV_W + 1)'(GEAR_OFS_I);
    localparam logic [pisc_pkg::GV_W-1:0] GEAR_RCP  = pisc_pkg::GV_W'(GEAR_RCP_I);
    localparam logic [pisc_pkg::GV_W-1:0] GEAR_MODV = pisc_pkg::GV_W'(GEAR_MODULUS);
    localparam logic [pisc_pkg::SUM_W-1:0] ILIM_S = pisc_pkg::SUM_W'(INTEGRAL_LIMIT);
    localparam logic [pisc_pkg::INTEG_W-1:0] ILIM = pisc_pkg::INTEG_W'(INTEGRAL_LIMIT);
    localparam logic [pisc_pkg::SUM_W-pisc_pkg::SUM_SHIFT-1:0] DMAX_S =
        (pisc_pkg::SUM_W - pisc_pkg::SUM_SHIFT)'(pisc_pkg::DUTY_MAX);
    localparam logic [pisc_pkg::DUTY_W-1:0] DMAX = pisc_pkg::DUTY_W'(pisc_pkg::DUTY_MAX);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pisc_pkg::GAIN_W-1:0] r_prop_gain;
    logic [pisc_pkg::GAIN_W-1:0] r_integ_gain;
    logic [pisc_pkg::PER_W-1:0]  r_pwm_period;
    logic                        w_cfg_wr;
    pisc_pkg::t_reg_idx          w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = pisc_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= pisc_pkg::PROP_GAIN_RST;
            r_integ_gain <= pisc_pkg::INTEG_GAIN_RST;
            r_pwm_period <= pisc_pkg::PWM_PERIOD_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                pisc_pkg::REG_PROP_GAIN:  r_prop_gain  <= pwdata[pisc_pkg::GAIN_W-1:0];
                pisc_pkg::REG_INTEG_GAIN: r_integ_gain <= pwdata[pisc_pkg::GAIN_W-1:0];
                pisc_pkg::REG_PWM_PERIOD: r_pwm_period <= pwdata[pisc_pkg::PER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            pisc_pkg::REG_PROP_GAIN:  prdata = {24'd0, r_prop_gain};
            pisc_pkg::REG_INTEG_GAIN: prdata = {24'd0, r_integ_gain};
            pisc_pkg::REG_PWM_PERIOD: prdata = {16'd0, r_pwm_period};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: step counter and control word
    // ------------------------------------------------------------------
    logic [pisc_pkg::STEP_W-1:0] r_step;
    logic [pisc_pkg::STEP_W-1:0] n_step;
    pisc_pkg::t_uc_word          w_uc;
    logic                        w_go;
    logic                        r_out_valid;

    assign w_uc = pisc_pkg::uc_rom(r_step);

    always_comb begin
        case (w_uc.cond)
            pisc_pkg::CND_ALWAYS:   w_go = 1'b1;
            pisc_pkg::CND_IN_WORD:  w_go = i_s_tvalid;
            pisc_pkg::CND_OUT_FREE: w_go = !r_out_valid || i_m_tready;
            default:                w_go = 1'b0;
        endcase
    end

    assign n_step     = w_go ? w_uc.target : r_step;
    assign o_s_tready = (w_uc.cond == pisc_pkg::CND_IN_WORD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic signed [pisc_pkg::ERR_W-1:0]  r_err;
    logic [pisc_pkg::DUTY_W-1:0]        r_duty;
    logic [pisc_pkg::GV_W-1:0]          r_gv;
    logic [pisc_pkg::GV_W-1:0]          r_q;
    logic [pisc_pkg::CMP_X_W-1:0]       r_x;
    logic                               r_zero_pos;
    logic signed [pisc_pkg::PROD_W-1:0] r_prod;

    logic [pisc_pkg::INTEG_W-1:0]       r_integ;
    logic [pisc_pkg::COUNT_W-1:0]       r_travel;
    logic [pisc_pkg::COUNT_W-1:0]       r_segment;
    logic [pisc_pkg::GEAR_W-1:0]        r_gear;

    // Input word fields.
    logic signed [pisc_pkg::DELTA_W-1:0] w_delta;
    logic [pisc_pkg::TARGET_W-1:0]       w_target;
    logic                                w_reverse;
    logic                                w_clr_travel;
    logic                                w_clr_segment;
    logic                                w_zero_pos;

    assign w_delta       = $signed(i_s_tdata[15:0]);
    assign w_target      = i_s_tdata[23:16];
    assign w_reverse     = i_s_tdata[24];
    assign w_clr_travel  = i_s_tdata[25];
    assign w_clr_segment = i_s_tdata[26];
    assign w_zero_pos    = i_s_tdata[27];

    // Speed error: twice the target, minus the delta going forward and plus
    // the delta in reverse.
    logic signed [pisc_pkg::ERR_W-1:0] w_dbl;
    logic signed [pisc_pkg::ERR_W-1:0] w_d17;
    logic signed [pisc_pkg::ERR_W-1:0] w_err;
    logic [pisc_pkg::COUNT_W-1:0]      w_d32;
    logic [pisc_pkg::GV_W:0]           w_gv;

    assign w_dbl = $signed({8'd0, w_target, 1'b0});
    assign w_d17 = $signed({w_delta[15], w_delta});
    assign w_err = w_reverse ? (w_dbl + w_d17) : (w_dbl - w_d17);
    assign w_d32 = {{16{w_delta[15]}}, w_delta};
    assign w_gv  = {4'd0, r_gear} + {{2{w_delta[15]}}, w_delta} + GEAR_OFS;

    // Shared multiplier operands.
    logic signed [pisc_pkg::MUL_W-1:0] w_mul_a;
    logic signed [pisc_pkg::MUL_W-1:0] w_mul_b;

    always_comb begin
        case (w_uc.mul)
            pisc_pkg::MUL_ERR_IG: begin
                w_mul_a = {{8{r_err[16]}}, r_err};
                w_mul_b = {17'd0, r_integ_gain};
            end
            pisc_pkg::MUL_ERR_PG: begin
                w_mul_a = {{8{r_err[16]}}, r_err};
                w_mul_b = {17'd0, r_prop_gain};
            end
            pisc_pkg::MUL_GV_RCP: begin
                w_mul_a = {8'd0, r_gv};
                w_mul_b = {8'd0, GEAR_RCP};
            end
            pisc_pkg::MUL_DUTY_PER: begin
                w_mul_a = {18'd0, r_duty};
                w_mul_b = {9'd0, r_pwm_period};
            end
            pisc_pkg::MUL_Q_MOD: begin
                w_mul_a = {8'd0, r_q};
                w_mul_b = {8'd0, GEAR_MODV};
            end
            pisc_pkg::MUL_X_RCP: begin
                w_mul_a = {2'd0, r_x};
                w_mul_b = {1'b0, pisc_pkg::CMP_RECIP};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Integral with anti-windup clamp.
    logic [pisc_pkg::SUM_W-1:0]   w_isum;
    logic [pisc_pkg::INTEG_W-1:0] w_integ;

    assign w_isum = r_prod[pisc_pkg::SUM_W-1:0] + {15'd0, r_integ};

    always_comb begin
        if (w_isum[pisc_pkg::SUM_W-1]) begin
            w_integ = '0;
        end else if (w_isum >= ILIM_S) begin
            w_integ = ILIM;
        end else begin
            w_integ = w_isum[pisc_pkg::INTEG_W-1:0];
        end
    end

    // Controller sum, shifted and clamped to a duty percent. A sum at or
    // below zero gives zero duty.
    logic [pisc_pkg::SUM_W-1:0]                    w_dsum;
    logic [pisc_pkg::SUM_W-pisc_pkg::SUM_SHIFT-1:0] w_dshift;
    logic [pisc_pkg::DUTY_W-1:0]                   w_duty;

    assign w_dsum   = r_prod[pisc_pkg::SUM_W-1:0] + {15'd0, r_integ};
    assign w_dshift = w_dsum[pisc_pkg::SUM_W-1:pisc_pkg::SUM_SHIFT];

    always_comb begin
        if (w_dsum[pisc_pkg::SUM_W-1] || (w_dsum == '0)) begin
            w_duty = '0;
        end else if (w_dshift > DMAX_S) begin
            w_duty = DMAX;
        end else begin
            w_duty = w_dshift[pisc_pkg::DUTY_W-1:0];
        end
    end

    // Final gear correction: the remainder is below two turns.
    logic [pisc_pkg::GV_W-1:0]   w_grem;
    logic [pisc_pkg::GEAR_W-1:0] w_gear;
    logic [pisc_pkg::CMP_W-1:0]  w_cmp;

    assign w_grem = (r_gv >= GEAR_MODV) ? (r_gv - GEAR_MODV) : r_gv;
    assign w_gear = r_zero_pos ? '0 : w_grem[pisc_pkg::GEAR_W-1:0];
    assign w_cmp  = r_prod[pisc_pkg::CMP_SHIFT +: pisc_pkg::CMP_W];

    logic w_wb;
    assign w_wb = w_go;

    // Working registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_uc.mul != pisc_pkg::MUL_NONE) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (w_wb) begin
            case (w_uc.wb)
                pisc_pkg::WB_LOAD: begin
                    r_err      <= w_err;
                    r_gv       <= w_gv[pisc_pkg::GV_W-1:0];
                    r_zero_pos <= w_zero_pos;
                end
                pisc_pkg::WB_DUTY: r_duty <= w_duty;
                pisc_pkg::WB_GQ:   r_q    <= r_prod[pisc_pkg::GV_W +: pisc_pkg::GV_W];
                pisc_pkg::WB_X:    r_x    <= r_prod[pisc_pkg::CMP_X_W-1:0];
                pisc_pkg::WB_GREM: r_gv   <= r_gv - r_prod[pisc_pkg::GV_W-1:0];
                default: ;
            endcase
        end
    end

    // Controller and counter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ   <= '0;
            r_travel  <= '0;
            r_segment <= '0;
            r_gear    <= '0;
        end else if (w_wb) begin
            case (w_uc.wb)
                pisc_pkg::WB_LOAD: begin
                    // Clearing the travel counter clears the segment too;
                    // the delta is added after either clear.
                    if (w_clr_travel) begin
                        r_travel  <= w_d32;
                        r_segment <= w_d32;
                    end else begin
                        r_travel  <= r_travel + w_d32;
                        r_segment <= (w_clr_segment ? '0 : r_segment) + w_d32;
                    end
                end
                pisc_pkg::WB_INTEG:  r_integ <= w_integ;
                pisc_pkg::WB_FINISH: r_gear  <= w_gear;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                        w_finish;
    logic [pisc_pkg::OUT_W-1:0]  r_out_data;

    assign w_finish = w_wb && (w_uc.wb == pisc_pkg::WB_FINISH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_data <= {6'd0, w_gear, r_segment, r_travel, r_integ,
                           r_err, w_cmp, r_duty};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> tb/sv/pi_speed_controller_with_position_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the PI speed controller with position tracking
// Drives sampling ticks into the slave stream and programs the gains and the
// PWM period over the APB-style port. A behavioral model of the controller
// predicts every result word, and a checker compares each word on the master
// stream with the oldest prediction, field by field. Both streams idle at
// random; one phase holds the receiver off long enough to stall the input.
// ----------------------------------------------------------------------------
module pi_speed_controller_with_position_core_tb;

    localparam int DELTA_W  = pisc_pkg::DELTA_W;
    localparam int TARGET_W = pisc_pkg::TARGET_W;
    localparam int DUTY_W   = pisc_pkg::DUTY_W;
    localparam int CMP_W    = pisc_pkg::CMP_W;
    localparam int ERR_W    = pisc_pkg::ERR_W;
    localparam int INTEG_W  = pisc_pkg::INTEG_W;
    localparam int COUNT_W  = pisc_pkg::COUNT_W;
    localparam int GEAR_W   = pisc_pkg::GEAR_W;
    localparam int IN_W     = pisc_pkg::IN_W;
    localparam int OUT_W    = pisc_pkg::OUT_W;
    localparam int APB_AW   = pisc_pkg::APB_AW;
    localparam int APB_DW   = pisc_pkg::APB_DW;
    localparam int GAIN_W   = pisc_pkg::GAIN_W;
    localparam int PER_W    = pisc_pkg::PER_W;

    localparam int CLK_PERIOD   = 10;
    localparam int GEAR_MOD     = pisc_pkg::GEAR_MODULUS_DEF;
    localparam int INTEG_MAX    = pisc_pkg::INTEGRAL_LIMIT_DEF;
    // Time one tick takes through the control program; the waits scale with it.
    localparam int TICK_LATENCY = 8;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int RANDOM_TICKS = 1500;
    localparam int STEADY_TICKS = 300;
    localparam int PHASE_TICKS  = 300;

    // One sampling tick as it travels on the slave stream.
    typedef struct {
        logic signed [DELTA_W-1:0]  delta;
        logic        [TARGET_W-1:0] target;
        logic                       reverse;
        logic                       clear_travel;
        logic                       clear_segment;
        logic                       zero_position;
    } t_tick;

    // One controller status word as it travels on the master stream.
    typedef struct {
        logic [DUTY_W-1:0]  duty;
        logic [CMP_W-1:0]   cmp;
        logic [ERR_W-1:0]   err;
        logic [INTEG_W-1:0] integ;
        logic [COUNT_W-1:0] travel;
        logic [COUNT_W-1:0] segment;
        logic [GEAR_W-1:0]  gear;
    } t_status;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [IN_W-1:0]    i_s_tdata;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [OUT_W-1:0]   o_m_tdata;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // Controller model: its own copy of the registers and the state.
    logic [GAIN_W-1:0]  kp_q;
    logic [GAIN_W-1:0]  ki_q;
    logic [PER_W-1:0]   period_q;
    longint             integ_q;
    logic [COUNT_W-1:0] travel_q;
    logic [COUNT_W-1:0] segment_q;
    longint             gear_q;

    // Predicted status words, oldest first.
    t_status status_q[$];

    int n_ticks   = 0;
    int n_results = 0;
    int n_errors  = 0;

    // Idling controls. The receiver takes a long hold-off when sink_hold is
    // set to a nonzero cycle count.
    bit src_gaps  = 1'b1;
    bit sink_gaps = 1'b1;
    int sink_hold = 0;

    pi_speed_controller_with_position_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard limit on the run. The slowest correct run stays well below it.
    initial begin
        #20_000_000;
        $display("Run timed out at %0t ns", $time);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------------

    // Advances the model by one tick and returns the status word it yields.
    function automatic t_status predict_tick(input t_tick t);
        longint  d;
        longint  tgt;
        longint  err;
        longint  integ;
        longint  sum;
        longint  duty;
        longint  cmp;
        longint  g;
        t_status r;
        d   = t.delta;
        tgt = t.target;
        err = t.reverse ? (2 * tgt + d) : (2 * tgt - d);

        // The integral is clamped before it feeds the sum: anti-windup.
        integ = integ_q + longint'(ki_q) * err;
        if (integ >= INTEG_MAX)
            integ = INTEG_MAX;
        else if (integ <= 0)
            integ = 0;
        integ_q = integ;

        // Full-width sum; a negative sum always gives zero duty.
        sum = longint'(kp_q) * err + integ;
        if (sum <= 0) begin
            duty = 0;
        end else begin
            duty = sum >>> pisc_pkg::SUM_SHIFT;
            if (duty > pisc_pkg::DUTY_MAX)
                duty = pisc_pkg::DUTY_MAX;
        end
        cmp = (duty * longint'(period_q)) / pisc_pkg::DUTY_MAX;

        // Clearing travel also clears the segment; the delta is added after.
        if (t.clear_travel) begin
            travel_q  = '0;
            segment_q = '0;
        end
        if (t.clear_segment)
            segment_q = '0;
        travel_q  = travel_q + d[COUNT_W-1:0];
        segment_q = segment_q + d[COUNT_W-1:0];

        // The gear position takes the true nonnegative remainder.
        if (t.zero_position) begin
            gear_q = 0;
        end else begin
            g = (gear_q + d) % GEAR_MOD;
            if (g < 0)
                g += GEAR_MOD;
            gear_q = g;
        end

        r.duty    = duty[DUTY_W-1:0];
        r.cmp     = cmp[CMP_W-1:0];
        r.err     = err[ERR_W-1:0];
        r.integ   = integ[INTEG_W-1:0];
        r.travel  = travel_q;
        r.segment = segment_q;
        r.gear    = gear_q[GEAR_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_tick make_tick(input int delta, input int target, input bit rev,
                                        input bit clr_trv, input bit clr_seg,
                                        input bit zero_pos);
        t_tick t;
        t.delta         = DELTA_W'(delta);
        t.target        = TARGET_W'(target);
        t.reverse       = rev;
        t.clear_travel  = clr_trv;
        t.clear_segment = clr_seg;
        t.zero_position = zero_pos;
        return t;
    endfunction

    // Mostly small deltas, with full range and near-extreme values mixed in.
    function automatic t_tick random_tick();
        t_tick t;
        case ($urandom_range(0, 4))
            0: t.delta = DELTA_W'($urandom_range(0, 600) - 300);
            1: t.delta = DELTA_W'($urandom);
            2: t.delta = $urandom_range(0, 1) ? DELTA_W'(16'h8000 + $urandom_range(0, 15))
                                              : DELTA_W'(16'h7FFF - $urandom_range(0, 15));
            3: t.delta = DELTA_W'($urandom_range(0, 2 * GEAR_MOD) - GEAR_MOD);
            default: t.delta = DELTA_W'($urandom_range(0, 4000) - 2000);
        endcase
        t.target        = TARGET_W'($urandom_range(0, 255));
        t.reverse       = 1'($urandom_range(0, 1));
        t.clear_travel  = ($urandom_range(0, 9) == 0);
        t.clear_segment = ($urandom_range(0, 7) == 0);
        t.zero_position = ($urandom_range(0, 15) == 0);
        return t;
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom_range(1, 8));
            default: return GAIN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [PER_W-1:0] random_period();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return PER_W'($urandom_range(1, 200));
            default: return PER_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offers one tick, possibly after an idle burst, and records its
    // prediction once the word is accepted. The valid stays high on return
    // so that a following tick can go out back to back.
    task automatic send_tick(input t_tick t);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, t.zero_position, t.clear_segment, t.clear_travel,
                       t.reverse, t.target, t.delta};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        status_q.push_back(predict_tick(t));
        n_ticks++;
    endtask

    // Withdraws the valid after the last tick of a batch.
    task automatic stop_ticks();
        i_s_tvalid <= 1'b0;
    endtask

    // Waits for every predicted word, then for the block to settle.
    task automatic wait_drain();
        int waited;
        waited = 0;
        while (status_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (status_q.size() != 0) begin
            n_errors++;
            $display("%0t ns: %0d predicted words never arrived", $time, status_q.size());
            status_q.delete();
        end
        repeat (2 * TICK_LATENCY) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready. The bus rests
    // idle afterwards so that writes never overlap.
    task automatic write_reg(input pisc_pkg::t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pisc_pkg::REG_PROP_GAIN:  kp_q     = value[GAIN_W-1:0];
            pisc_pkg::REG_INTEG_GAIN: ki_q     = value[GAIN_W-1:0];
            pisc_pkg::REG_PWM_PERIOD: period_q = value[PER_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Must only be called with nothing in flight.
    task automatic set_config(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [PER_W-1:0] period);
        write_reg(pisc_pkg::REG_PROP_GAIN, APB_DW'(kp));
        write_reg(pisc_pkg::REG_INTEG_GAIN, APB_DW'(ki));
        write_reg(pisc_pkg::REG_PWM_PERIOD, APB_DW'(period));
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // Every accepted word on the master stream is matched with the oldest
    // prediction. The packing follows the port comment of the block.
    always @(posedge i_clk) begin : check_results
        t_status got;
        t_status want;
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            got.duty    = o_m_tdata[6:0];
            got.cmp     = o_m_tdata[22:7];
            got.err     = o_m_tdata[39:23];
            got.integ   = o_m_tdata[51:40];
            got.travel  = o_m_tdata[83:52];
            got.segment = o_m_tdata[115:84];
            got.gear    = o_m_tdata[129:116];
            n_results++;
            if (status_q.size() == 0) begin
                n_errors++;
                $display("%0t ns: unexpected word, expected none, actual %0h",
                         $time, o_m_tdata);
            end else begin
                want = status_q.pop_front();
                check_field("duty_percent", COUNT_W'(want.duty), COUNT_W'(got.duty));
                check_field("compare_value", COUNT_W'(want.cmp), COUNT_W'(got.cmp));
                check_field("speed_error", COUNT_W'(want.err), COUNT_W'(got.err));
                check_field("integral_value", COUNT_W'(want.integ), COUNT_W'(got.integ));
                check_field("travel_ticks", want.travel, got.travel);
                check_field("segment_ticks", want.segment, got.segment);
                check_field("gear_angle", COUNT_W'(want.gear), COUNT_W'(got.gear));
            end
        end
    end

    // Receiver: random stall bursts, and a long hold-off on request that is
    // counted here so the sender keeps offering words meanwhile.
    initial begin
        i_m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (sink_hold > 0) begin
                i_m_tready <= 1'b0;
                repeat (sink_hold) @(posedge i_clk);
                sink_hold = 0;
            end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, every direction and flag, and the special cases, at the
    // reset register values and then at the register extremes.
    task automatic test_directed();
        send_tick(make_tick(0, 0, 0, 0, 0, 0));
        send_tick(make_tick(-10, 50, 0, 0, 0, 0));
        // Huge positive delta forward: the sum goes negative, duty is zero.
        send_tick(make_tick(32767, 0, 0, 0, 0, 0));
        // Largest error: the integral saturates high and the duty at 100.
        send_tick(make_tick(-32768, 255, 0, 0, 0, 0));
        // Smallest error in reverse, and a delta below minus one gear turn.
        send_tick(make_tick(-32768, 0, 1, 0, 0, 0));
        send_tick(make_tick(32767, 255, 1, 0, 0, 0));
        // All clear flags together.
        send_tick(make_tick(1000, 10, 0, 1, 1, 1));
        send_tick(make_tick(-5, 10, 0, 0, 1, 0));
        send_tick(make_tick(-32768, 0, 0, 0, 0, 1));
        // Walk the gear position across the modulus boundary both ways.
        send_tick(make_tick(GEAR_MOD - 1, 100, 1, 0, 0, 0));
        send_tick(make_tick(1, 100, 1, 0, 0, 0));
        send_tick(make_tick(-1, 100, 0, 0, 0, 0));
        send_tick(make_tick(-32768, 128, 0, 1, 0, 0));
        stop_ticks();
        wait_drain();

        // A zero period forces a zero compare value.
        set_config(8'd1, 8'd1, 16'd0);
        send_tick(make_tick(-200, 200, 0, 0, 0, 0));
        send_tick(make_tick(32767, 0, 1, 0, 0, 0));
        stop_ticks();
        wait_drain();

        // Largest gains and period.
        set_config(8'hFF, 8'hFF, 16'hFFFF);
        send_tick(make_tick(-32768, 255, 0, 0, 0, 0));
        send_tick(make_tick(-32768, 0, 1, 0, 0, 0));
        send_tick(make_tick(3, 2, 0, 0, 0, 0));
        stop_ticks();
        wait_drain();

        // Zero gains: nothing moves the integral and the duty comes from it alone.
        set_config(8'd0, 8'd0, 16'd1200);
        send_tick(make_tick(-32768, 255, 0, 0, 0, 0));
        send_tick(make_tick(100, 255, 1, 0, 0, 0));
        stop_ticks();
        wait_drain();
    endtask

    // Random ticks in phases of fixed register settings, the first two phases at
    // the extremes, the third at the reset values, later ones at random. Halfway
    // through each phase the sender pauses until every predicted word is back.
    task automatic test_random(input int count);
        int phase;
        phase = 0;
        for (int i = 0; i < count; i++) begin
            if (i % PHASE_TICKS == 0) begin
                stop_ticks();
                wait_drain();
                case (phase)
                    0:       set_config(8'hFF, 8'hFF, 16'hFFFF);
                    1:       set_config(8'd0, 8'd0, 16'd0);
                    2:       set_config(pisc_pkg::PROP_GAIN_RST, pisc_pkg::INTEG_GAIN_RST,
                                        pisc_pkg::PWM_PERIOD_RST);
                    default: set_config(random_gain(), random_gain(), random_period());
                endcase
                phase++;
            end else if (i % PHASE_TICKS == PHASE_TICKS / 2) begin
                stop_ticks();
                wait_drain();
            end
            send_tick(random_tick());
        end
        stop_ticks();
        wait_drain();
    endtask

    // The receiver holds off long enough for the output register and the
    // program to fill, so the slave stream must stall.
    task automatic test_backpressure();
        sink_hold = 40 * TICK_LATENCY;
        for (int i = 0; i < 20; i++)
            send_tick(random_tick());
        stop_ticks();
        wait_drain();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_steady(input int count);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        set_config(random_gain(), random_gain(), random_period());
        for (int i = 0; i < count; i++)
            send_tick(random_tick());
        stop_ticks();
        wait_drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;

        // The model starts from the reset values of the block.
        kp_q      = pisc_pkg::PROP_GAIN_RST;
        ki_q      = pisc_pkg::INTEG_GAIN_RST;
        period_q  = pisc_pkg::PWM_PERIOD_RST;
        integ_q   = 0;
        travel_q  = '0;
        segment_q = '0;
        gear_q    = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed();
        test_random(RANDOM_TICKS);
        test_backpressure();
        test_steady(STEADY_TICKS);

        $display("Covered %0d ticks, %0d result words: directed extremes, random phases,",
                 n_ticks, n_results);
        $display("register extremes and a long receiver stall; %0d mismatches.",
                 n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/pisc_pkg.sv
rtl/core/pi_speed_controller_with_position_core.sv
tb/sv/pi_speed_controller_with_position_core_tb.sv
